FILE: rtl/core/lep_pkg.sv
// ----------------------------------------------------------------------------
// lep_pkg: shared types for the loop and event profiling meter
// Command codes, status codes, the per-type table entry and the loop
// statistics record passed from the counter block to the top level.
// ----------------------------------------------------------------------------
package lep_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_BEGIN  = 3'd0,
        CMD_END    = 3'd1,
        CMD_SAMPLE = 3'd2,
        CMD_RECENT = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_START  = 3'd5,
        CMD_STOP   = 3'd6,
        CMD_READ   = 3'd7
    } cmd_t;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_SAME    = 2'd2;

    // one per-type table entry
    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [63:0] max_ticks;
    } type_entry_t;

    // loop statistics after a request took effect
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] last_ticks;
        logic [31:0] last_events;
        logic [63:0] total_ticks;
        logic [31:0] total_events;
        logic [31:0] total_loops;
        logic [63:0] recent_ticks;
        logic [31:0] recent_events;
        logic [31:0] recent_loops;
    } loop_stats_t;

    // table operation for the request in the execute stage
    typedef struct packed {
        logic fire;
        logic sample;
        logic clear;
    } type_op_t;

endpackage

FILE: rtl/core/lep_type_store.sv
// ----------------------------------------------------------------------------
// lep_type_store: per-type sample statistics memory
// One synchronous memory of count, tick sum and maximum per type, read at
// accept and written back in the execute stage, with a forwarding path for
// a write to the same entry in the read cycle. Valid bits empty the table.
// ----------------------------------------------------------------------------
module lep_type_store
    import lep_pkg::*;
#(
    parameter int NUM_TYPES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [5:0]  rd_type,
    input  logic [5:0]  ex_type,
    input  logic [63:0] ex_sample,
    input  type_op_t    op,
    output type_entry_t entry
);

    // only types reachable by a 6-bit index are stored
    localparam int ENTRIES = (NUM_TYPES < 64) ? NUM_TYPES : 64;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [10:0] NUM_TYPES_L = 11'(NUM_TYPES);

    type_entry_t        type_mem [ENTRIES];
    type_entry_t        rd_data_reg;
    type_entry_t        fwd_entry_reg;
    logic               fwd_hit_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   ex_idx;
    logic               in_range;
    logic               hit;
    logic               wr_en;
    type_entry_t        cur;
    type_entry_t        upd;

    assign rd_idx   = rd_type[IDX_W-1:0];
    assign ex_idx   = ex_type[IDX_W-1:0];
    assign in_range = ({5'b0, ex_type} < NUM_TYPES_L);
    assign hit      = in_range && valid_reg[ex_idx];
    assign wr_en    = op.fire && op.sample && in_range;

    // current entry, taking the write made in the read cycle if any
    assign cur = fwd_hit_reg ? fwd_entry_reg : rd_data_reg;

    // sample update: start afresh on an empty entry
    always_comb
    begin
        if (hit)
        begin
            upd.count     = cur.count + 32'd1;
            upd.sum       = cur.sum + ex_sample;
            upd.max_ticks = (cur.max_ticks < ex_sample) ? ex_sample : cur.max_ticks;
        end
        else
        begin
            upd.count     = 32'd1;
            upd.sum       = ex_sample;
            upd.max_ticks = ex_sample;
        end
    end

    // entry as seen after the request
    always_comb
    begin
        if (op.clear)
            entry = '0;
        else if (op.sample && in_range)
            entry = upd;
        else if (hit)
            entry = cur;
        else
            entry = '0;
    end

    // valid bits
    always_comb
    begin
        valid_next = valid_reg;
        if (op.fire && op.clear)
            valid_next = '0;
        else if (wr_en)
            valid_next[ex_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
                fwd_hit_reg <= wr_en && (ex_idx == rd_idx);
        end
    end

    // memory port and forwarding data
    always_ff @(posedge clk)
    begin
        if (wr_en)
            type_mem[ex_idx] <= upd;
        if (rd_en)
        begin
            rd_data_reg   <= type_mem[rd_idx];
            fwd_entry_reg <= upd;
        end
    end

`ifndef SYNTH
    // an executed clear empties the whole table
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (op.fire && op.clear) |=> (valid_reg == '0))
        else $error("type table not emptied by clear");
`endif

endmodule

FILE: rtl/core/lep_loop_counters.sv
// ----------------------------------------------------------------------------
// lep_loop_counters: run state and loop statistics
// Holds the run flag, the begin tick and the last, total and recent sums,
// and computes the status and the statistics after each request.
// ----------------------------------------------------------------------------
module lep_loop_counters
    import lep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  cmd_t        cmd,
    input  logic [63:0] tick,
    input  logic [31:0] events,
    output logic        running,
    output loop_stats_t stats
);

    logic        running_reg, running_next;
    logic [63:0] start_tick_reg, start_tick_next;
    loop_stats_t stats_reg;

    assign running = running_reg;

    // next state and status for the request in the execute stage
    always_comb
    begin
        running_next    = running_reg;
        start_tick_next = start_tick_reg;
        stats           = stats_reg;
        stats.status    = ST_OK;
        case (cmd)
            CMD_START:
            begin
                if (running_reg)
                    stats.status = ST_SAME;
                else
                    running_next = 1'b1;
            end
            CMD_STOP:
            begin
                if (!running_reg)
                    stats.status = ST_SAME;
                else
                    running_next = 1'b0;
            end
            default:
            begin
                if (!running_reg)
                    stats.status = ST_STOPPED;
                else
                begin
                    case (cmd)
                        CMD_BEGIN:
                            start_tick_next = tick;
                        CMD_END:
                        begin
                            stats.last_ticks    = tick - start_tick_reg;
                            stats.last_events   = events;
                            stats.total_ticks   = stats_reg.total_ticks + stats.last_ticks;
                            stats.total_events  = stats_reg.total_events + events;
                            stats.total_loops   = stats_reg.total_loops + 32'd1;
                            stats.recent_ticks  = stats_reg.recent_ticks + stats.last_ticks;
                            stats.recent_events = stats_reg.recent_events + events;
                            stats.recent_loops  = stats_reg.recent_loops + 32'd1;
                        end
                        CMD_RECENT:
                        begin
                            stats.recent_ticks  = '0;
                            stats.recent_events = '0;
                            stats.recent_loops  = '0;
                        end
                        CMD_CLEAR:
                        begin
                            stats        = '0;
                            stats.status = ST_OK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            start_tick_reg <= '0;
            stats_reg      <= '0;
        end
        else if (fire)
        begin
            running_reg    <= running_next;
            start_tick_reg <= start_tick_next;
            stats_reg      <= stats;
        end
    end

`ifndef SYNTH
    // an accepted stop always leaves the meter stopped
    a_stop_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (cmd == CMD_STOP)) |=> !running_reg)
        else $error("meter still running after stop");

    // a completed end loop counts exactly one loop
    a_end_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (cmd == CMD_END) && running_reg) |=>
        (stats_reg.total_loops == $past(stats_reg.total_loops) + 32'd1))
        else $error("end loop did not count one loop");
`endif

endmodule

FILE: rtl/core/loop_and_event_profiling_meter.sv
// ----------------------------------------------------------------------------
// loop_and_event_profiling_meter: loop timing and per-type sample profiler
// Usage:
//   Request channel: in_valid/in_stall carry command, current_tick,
//   event_count, element_type and sample_ticks. A request is taken at a
//   clock edge with in_valid high and in_stall low.
//   Result channel: out_valid/out_stall carry one result per request,
//   status plus loop and per-type statistics after the request.
//   Result path: an accepted request is held in the execute stage register and
//   its result is registered in the output register, where it can be taken.
//   Throughput: one request per cycle while in_stall is low; each request does
//   one read of the per-type memory at accept, an in-range sample taken while
//   running writes back in the execute stage; a write to the entry read is forwarded.
//   Reset: the meter is stopped, all sums are zero and the per-type table
//   is empty; no clearing pass is needed.
//   A stalled result holds the output register; one more request can sit
//   in the execute stage, after which in_stall rises until the result moves.
// ----------------------------------------------------------------------------
module loop_and_event_profiling_meter
    import lep_pkg::*;
#(
    parameter int NUM_TYPES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [63:0] current_tick,
    input  logic [31:0] event_count,
    input  logic [5:0]  element_type,
    input  logic [63:0] sample_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] last_loop_ticks,
    output logic [31:0] last_loop_events,
    output logic [63:0] total_ticks,
    output logic [31:0] total_events,
    output logic [31:0] total_loops,
    output logic [63:0] recent_ticks,
    output logic [31:0] recent_events,
    output logic [31:0] recent_loops,
    output logic [31:0] type_samples,
    output logic [63:0] type_tick_sum,
    output logic [63:0] type_max_ticks
);

    logic        b_valid_reg, b_valid_next;
    cmd_t        b_cmd_reg;
    logic [63:0] b_tick_reg;
    logic [31:0] b_events_reg;
    logic [5:0]  b_type_reg;
    logic [63:0] b_sample_reg;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        b_fire;
    logic        in_accept;
    logic        running;
    loop_stats_t stats;
    type_entry_t entry;
    type_op_t    op;

    // handshake and stage advance
    assign out_free  = !out_valid_reg || !out_stall;
    assign b_fire    = b_valid_reg && out_free;
    assign in_stall  = b_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (in_accept)
            b_valid_next = 1'b1;
        else if (b_fire)
            b_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (b_fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // execute stage request fields
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            b_cmd_reg    <= cmd_t'(command);
            b_tick_reg   <= current_tick;
            b_events_reg <= event_count;
            b_type_reg   <= element_type;
            b_sample_reg <= sample_ticks;
        end
    end

    // table operation, only while running
    assign op.fire   = b_fire;
    assign op.sample = running && (b_cmd_reg == CMD_SAMPLE);
    assign op.clear  = running && ((b_cmd_reg == CMD_BEGIN) || (b_cmd_reg == CMD_CLEAR));

    lep_loop_counters u_counters (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (b_fire),
        .cmd     (b_cmd_reg),
        .tick    (b_tick_reg),
        .events  (b_events_reg),
        .running (running),
        .stats   (stats)
    );

    lep_type_store #(
        .NUM_TYPES (NUM_TYPES)
    ) u_type_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_type   (element_type),
        .ex_type   (b_type_reg),
        .ex_sample (b_sample_reg),
        .op        (op),
        .entry     (entry)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            status           <= stats.status;
            last_loop_ticks  <= stats.last_ticks;
            last_loop_events <= stats.last_events;
            total_ticks      <= stats.total_ticks;
            total_events     <= stats.total_events;
            total_loops      <= stats.total_loops;
            recent_ticks     <= stats.recent_ticks;
            recent_events    <= stats.recent_events;
            recent_loops     <= stats.recent_loops;
            type_samples     <= entry.count;
            type_tick_sum    <= entry.sum;
            type_max_ticks   <= entry.max_ticks;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // requests are held back only while the execute stage is occupied
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> b_valid_reg)
        else $error("request stalled with empty execute stage");

    // a request leaving the execute stage always shows up as a result
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire |=> out_valid)
        else $error("executed request produced no result");
`endif

endmodule
